FILE: design/hbsn_pkg.sv
// Shared widths, codes and helpers for the histogram bin / smooth / normalize core.
// No dependencies; imported by every other design file except hbsn_ram.
package hbsn_pkg;

    localparam int MAX_BINS_DEF = 1024;

    localparam int VAL_W    = 48;   // bin value, signed Q32.16
    localparam int EDGE_W   = 32;   // edge and sample, signed Q16.16
    localparam int SAMPLE_W = 32;
    localparam int PASS_W   = 8;
    localparam int EXP_W    = 2;
    localparam int IDX_W    = 10;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 3;
    localparam int MISS_W   = 32;
    localparam int CNT_W    = 11;   // bin_count register
    localparam int WID_W    = 31;   // bin_width / inverse_width registers
    localparam int NUM_W    = 64;   // divider numerator / quotient
    localparam int CHUNK_W  = 16;   // multiplier digit width
    localparam int MUL_STEPS = VAL_W / CHUNK_W;
    localparam int PROD_W   = VAL_W + EDGE_W;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 32;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 112;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SMOOTH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NORM   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 3'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD  = 3'd3;
    localparam logic [STAT_W-1:0] ST_SAT  = 3'd4;

    localparam logic [CFG_AW-1:0] REG_BIN_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_START     = 2'd1;
    localparam logic [CFG_AW-1:0] REG_WIDTH     = 2'd2;
    localparam logic [CFG_AW-1:0] REG_INV_WIDTH = 2'd3;

    localparam logic [CNT_W-1:0]  BIN_COUNT_RST = 11'd100;
    localparam logic [WID_W-1:0]  WIDTH_RST     = 31'd6554;
    localparam logic [WID_W-1:0]  INV_WIDTH_RST = 31'd655360;

    localparam logic signed [VAL_W-1:0] VAL_MAX      = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_ADD_LIM  = 48'sh7FFF_FFFE_FFFF;
    localparam logic signed [VAL_W-1:0] ONE_Q16      = 48'sh0000_0001_0000;
    localparam logic [NUM_W-1:0]        POS_LIM      = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [NUM_W-1:0]        NEG_LIM      = 64'h0000_8000_0000_0000;

    // Sign a magnitude into 48 bits with saturation; MSB of result = clipped.
    function automatic logic [VAL_W:0] sat_signed(input logic [NUM_W-1:0] mag,
                                                  input logic neg);
        logic [NUM_W-1:0] lim;
        logic             over;
        logic [VAL_W-1:0] m;
        lim  = neg ? NEG_LIM : POS_LIM;
        over = mag > lim;
        m    = over ? lim[VAL_W-1:0] : mag[VAL_W-1:0];
        return {over, (neg ? (-m) : m)};
    endfunction

endpackage

FILE: design/hbsn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module hbsn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/hbsn_div.sv
// Restoring divider, one quotient bit per cycle, for bin normalization.
// Depends on hbsn_pkg.
module hbsn_div #(
    parameter int DEN_W = 58
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [hbsn_pkg::NUM_W-1:0] num,
    input  logic [DEN_W-1:0]           den,
    output logic                       done,
    output logic [hbsn_pkg::NUM_W-1:0] quo
);
    import hbsn_pkg::*;

    localparam int CB = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CB-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            if (!diff[DEN_W]) begin
                rem_reg <= diff[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

FILE: design/hbsn_wmul.sv
// Digit-serial 48x32 magnitude multiplier, 16 bits of the wide operand per cycle.
// Depends on hbsn_pkg.
module hbsn_wmul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [hbsn_pkg::VAL_W-1:0]  a,
    input  logic [hbsn_pkg::EDGE_W-1:0] b,
    output logic                        done,
    output logic [hbsn_pkg::PROD_W-1:0] prod
);
    import hbsn_pkg::*;

    localparam int SB = $clog2(MUL_STEPS + 1);

    logic [VAL_W-1:0]           a_reg;
    logic [EDGE_W-1:0]          b_reg;
    logic [PROD_W-1:0]          acc_reg;
    logic [SB-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [CHUNK_W+EDGE_W-1:0]  part;

    assign part = a_reg[VAL_W-1 -: CHUNK_W] * b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SB'(MUL_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SB'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= {acc_reg[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + PROD_W'(part);
            a_reg   <= {a_reg[VAL_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: design/histogram_bin_smooth_normalize_core.sv
// Histogram core: bin store in one RAM, sequenced read-modify-write commands.
// Commands: add and read touch at most one bin, clear covers all MAX_BINS bins,
// and smooth, normalize and weight sweep the n bins in use.
// Throughput: one command at a time; the single RAM port pair and the serial
// divider/multiplier set the pace. After reset a clearing pass over all MAX_BINS
// bins runs with s_tready low; config writes are taken throughout.
module histogram_bin_smooth_normalize_core #(
    parameter int MAX_BINS = hbsn_pkg::MAX_BINS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sample[31:0], passes[39:32], exponent[41:40], bin_index[51:42], zero pad
    input  logic [hbsn_pkg::S_DATA_W-1:0] s_tdata,
    // command[2:0]
    input  logic [hbsn_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bin_value[47:0], bin_edge[79:48], miss_total[111:80]
    output logic [hbsn_pkg::M_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [hbsn_pkg::STAT_W-1:0]   m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [hbsn_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [hbsn_pkg::CFG_DW-1:0]   cfg_wr_data
);
    import hbsn_pkg::*;

    localparam int AW  = $clog2(MAX_BINS);
    localparam int CW  = $clog2(MAX_BINS + 1);
    localparam int IXW = (CW > IDX_W) ? CW : IDX_W;
    localparam int TW  = VAL_W + AW;          // exact sum of all bins
    localparam int EPW = AW + WID_W;          // index * width
    localparam int ESW = AW + EDGE_W + 1;     // start + index * width

    localparam logic [4:0] S_INIT    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_CLR     = 5'd2;
    localparam logic [4:0] S_ADD_MUL = 5'd3;
    localparam logic [4:0] S_ADD_RD  = 5'd4;
    localparam logic [4:0] S_ADD_WR  = 5'd5;
    localparam logic [4:0] S_SM_RUN  = 5'd6;
    localparam logic [4:0] S_SM_TAIL = 5'd7;
    localparam logic [4:0] S_SUM_RUN = 5'd8;
    localparam logic [4:0] S_SUM_END = 5'd9;
    localparam logic [4:0] S_N_RD    = 5'd10;
    localparam logic [4:0] S_N_DAT   = 5'd11;
    localparam logic [4:0] S_N_DIV   = 5'd12;
    localparam logic [4:0] S_W_RD    = 5'd13;
    localparam logic [4:0] S_W_DAT   = 5'd14;
    localparam logic [4:0] S_W_GO    = 5'd15;
    localparam logic [4:0] S_W_MUL   = 5'd16;
    localparam logic [4:0] S_RD_ISS  = 5'd17;
    localparam logic [4:0] S_RD_DAT  = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0]         bin_count_reg;
    logic signed [EDGE_W-1:0] start_reg;
    logic [WID_W-1:0]         bwidth_reg;
    logic [WID_W-1:0]         inv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_count_reg <= BIN_COUNT_RST;
            start_reg     <= '0;
            bwidth_reg    <= WIDTH_RST;
            inv_reg       <= INV_WIDTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BIN_COUNT: bin_count_reg <= cfg_wr_data[CNT_W-1:0];
                REG_START:     start_reg     <= cfg_wr_data;
                REG_WIDTH:     bwidth_reg    <= cfg_wr_data[WID_W-1:0];
                REG_INV_WIDTH: inv_reg       <= cfg_wr_data[WID_W-1:0];
                default: ;
            endcase
        end
    end

    // Bins in use, clamped to 2 .. MAX_BINS.
    logic [CW-1:0] n_bins;
    logic [CW-1:0] n_last;
    always_comb begin
        if (bin_count_reg < CNT_W'(2)) begin
            n_bins = CW'(2);
        end else if (32'(bin_count_reg) > MAX_BINS) begin
            n_bins = CW'(MAX_BINS);
        end else begin
            n_bins = CW'(bin_count_reg);
        end
    end
    assign n_last = n_bins - 1'b1;

    // ---------------- control and working registers ----------------
    logic [4:0]               state_reg;
    logic [CMD_W-1:0]         cmd_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [PASS_W-1:0]        passes_reg;
    logic [EXP_W-1:0]         expo_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [MISS_W-1:0]        miss_reg;
    logic [CW-1:0]            rd_cnt_reg;
    logic                     arr_valid_reg;
    logic [CW-1:0]            arr_idx_reg;
    logic signed [VAL_W-1:0]  prev1_reg;
    logic signed [VAL_W-1:0]  prev2_reg;
    logic signed [TW-1:0]     total_reg;
    logic [NUM_W-1:0]         prod_reg;
    logic signed [EDGE_W-1:0] edge_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic                     neg_reg;
    logic [EXP_W-1:0]         step_reg;
    logic                     sat_reg;
    logic [VAL_W-1:0]         res_value_reg;
    logic [EDGE_W-1:0]        res_edge_reg;
    logic [STAT_W-1:0]        res_status_reg;
    logic                     m_tvalid_reg;
    logic [VAL_W-1:0]         m_value_reg;
    logic [EDGE_W-1:0]        m_edge_reg;
    logic [MISS_W-1:0]        m_miss_reg;
    logic [STAT_W-1:0]        m_status_reg;

    // ---------------- datapath ----------------
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [VAL_W-1:0]         ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [VAL_W-1:0]         ram_rdata;
    logic signed [VAL_W-1:0]  rd_val;

    hbsn_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val = signed'(ram_rdata);

    logic [IXW-1:0] idx_ext;
    logic [AW-1:0]  idx_addr;
    logic           idx_bad;
    logic [CW-1:0]  arr_prev;
    logic           issue;

    assign idx_ext  = IXW'(idx_reg);
    assign idx_addr = idx_ext[AW-1:0];
    assign idx_bad  = idx_ext >= IXW'(n_bins);
    assign arr_prev = arr_idx_reg - 1'b1;
    assign issue    = rd_cnt_reg < n_bins;

    // Bin low edge: start + index * width, clipped to signed 32 bits.
    logic [AW-1:0]            edge_idx;
    logic [EPW-1:0]           e_prod;
    logic signed [ESW-1:0]    e_sum;
    logic signed [EDGE_W-1:0] edge_calc;

    assign edge_idx = (state_reg == S_RD_ISS) ? idx_addr : rd_cnt_reg[AW-1:0];
    assign e_prod   = EPW'(edge_idx) * EPW'(bwidth_reg);
    assign e_sum    = signed'({{(ESW-EDGE_W){start_reg[EDGE_W-1]}}, start_reg})
                    + signed'({2'b00, e_prod});
    always_comb begin
        if (e_sum[ESW-1:EDGE_W-1] == {(ESW-EDGE_W+1){e_sum[ESW-1]}}) begin
            edge_calc = e_sum[EDGE_W-1:0];
        end else if (e_sum[ESW-1]) begin
            edge_calc = {1'b1, {(EDGE_W-1){1'b0}}};
        end else begin
            edge_calc = {1'b0, {(EDGE_W-1){1'b1}}};
        end
    end

    // Sample binning: (sample - start) * inverse_width, Q32.32.
    logic signed [EDGE_W:0]  add_diff;
    logic signed [NUM_W:0]   add_prod;
    logic                    add_miss;
    logic [VAL_W-1:0]        add_wdata;
    logic                    add_sat;

    assign add_diff  = {sample_reg[SAMPLE_W-1], sample_reg} - {start_reg[EDGE_W-1], start_reg};
    assign add_prod  = add_diff * signed'({1'b0, inv_reg});
    assign add_miss  = prod_reg[NUM_W-1] || (prod_reg[NUM_W-1:32] >= 32'(n_bins));
    assign add_sat   = rd_val > VAL_ADD_LIM;
    assign add_wdata = add_sat ? VAL_MAX : (rd_val + ONE_Q16);

    // Smoothing tap sum x + 2*prev1 + y, floored by 4.
    logic signed [VAL_W-1:0] sm_x;
    logic signed [VAL_W-1:0] sm_y;
    logic signed [VAL_W+1:0] sm_sum;
    logic [VAL_W-1:0]        sm_wdata;

    assign sm_x = ((state_reg == S_SM_TAIL) || (arr_idx_reg == CW'(1))) ? prev1_reg : prev2_reg;
    assign sm_y = (state_reg == S_SM_TAIL) ? prev2_reg : rd_val;
    assign sm_sum = {{2{sm_x[VAL_W-1]}}, sm_x}
                  + {prev1_reg[VAL_W-1], prev1_reg, 1'b0}
                  + {{2{sm_y[VAL_W-1]}}, sm_y};
    assign sm_wdata = sm_sum[VAL_W+1:2];

    // Normalize divider.
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [TW-1:0]    div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [VAL_W-1:0] rd_mag;
    logic [VAL_W:0]   norm_res;

    assign rd_mag    = rd_val[VAL_W-1] ? (-ram_rdata) : ram_rdata;
    assign div_num   = {rd_mag, {(NUM_W-VAL_W){1'b0}}};
    assign div_den   = total_reg[TW-1] ? (-total_reg) : total_reg;
    assign div_start = (state_reg == S_N_DAT);
    assign norm_res  = sat_signed(div_quo, neg_reg);

    hbsn_div #(
        .DEN_W (TW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Weighting multiplier.
    logic              mul_start;
    logic [VAL_W-1:0]  mul_a;
    logic [EDGE_W-1:0] mul_b;
    logic              mul_done;
    logic [PROD_W-1:0] mul_prod;
    logic [VAL_W:0]    w_res;

    assign mul_start = (state_reg == S_W_GO);
    assign mul_a     = val_reg[VAL_W-1] ? (-val_reg) : val_reg;
    assign mul_b     = edge_reg[EDGE_W-1] ? (-edge_reg) : edge_reg;
    assign w_res     = sat_signed(mul_prod[PROD_W-1:CHUNK_W],
                                  val_reg[VAL_W-1] ^ edge_reg[EDGE_W-1]);

    hbsn_wmul u_wmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // ---------------- RAM port steering ----------------
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rd_cnt_reg[AW-1:0];
        ram_wdata = '0;
        case (state_reg)
            S_INIT, S_CLR: begin
                ram_we = 1'b1;
            end
            S_ADD_WR: begin
                ram_we    = 1'b1;
                ram_waddr = prod_reg[32 +: AW];
                ram_wdata = add_wdata;
            end
            S_SM_RUN: begin
                ram_we    = arr_valid_reg && (arr_idx_reg != '0);
                ram_waddr = arr_prev[AW-1:0];
                ram_wdata = sm_wdata;
            end
            S_SM_TAIL: begin
                ram_we    = 1'b1;
                ram_waddr = n_last[AW-1:0];
                ram_wdata = sm_wdata;
            end
            S_N_DIV: begin
                ram_we    = div_done;
                ram_wdata = norm_res[VAL_W-1:0];
            end
            S_W_MUL: begin
                ram_we    = mul_done && (step_reg == EXP_W'(1));
                ram_wdata = w_res[VAL_W-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_ADD_RD: ram_raddr = prod_reg[32 +: AW];
            S_RD_ISS: ram_raddr = idx_addr;
            default:  ram_raddr = rd_cnt_reg[AW-1:0];
        endcase
    end

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            rd_cnt_reg    <= '0;
            arr_valid_reg <= 1'b0;
            miss_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            sat_reg       <= 1'b0;
        end else begin
            arr_valid_reg <= 1'b0;
            edge_reg      <= edge_calc;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == CW'(MAX_BINS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg        <= s_tuser;
                        sample_reg     <= s_tdata[31:0];
                        passes_reg     <= s_tdata[39:32];
                        expo_reg       <= s_tdata[41:40];
                        idx_reg        <= s_tdata[51:42];
                        rd_cnt_reg     <= '0;
                        sat_reg        <= 1'b0;
                        total_reg      <= '0;
                        res_value_reg  <= '0;
                        res_edge_reg   <= '0;
                        res_status_reg <= ST_OK;
                        case (s_tuser)
                            CMD_CLEAR: begin
                                miss_reg  <= '0;
                                state_reg <= S_CLR;
                            end
                            CMD_ADD:    state_reg <= S_ADD_MUL;
                            CMD_SMOOTH: state_reg <= (s_tdata[39:32] == '0) ? S_DONE : S_SM_RUN;
                            CMD_NORM:   state_reg <= S_SUM_RUN;
                            CMD_WEIGHT: state_reg <= (s_tdata[41:40] == '0) ? S_DONE : S_W_RD;
                            CMD_READ:   state_reg <= S_RD_ISS;
                            default:    state_reg <= S_DONE;
                        endcase
                    end
                end
                S_CLR: begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == CW'(MAX_BINS - 1)) begin
                        state_reg <= S_DONE;
                    end
                end
                // ---- add sample ----
                S_ADD_MUL: begin
                    prod_reg  <= add_prod[NUM_W-1:0];
                    state_reg <= S_ADD_RD;
                end
                S_ADD_RD: begin
                    if (add_miss) begin
                        if (miss_reg != '1) begin
                            miss_reg <= miss_reg + 1'b1;
                        end
                        res_status_reg <= ST_MISS;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_ADD_WR;
                    end
                end
                S_ADD_WR: begin
                    res_status_reg <= add_sat ? ST_SAT : ST_OK;
                    state_reg      <= S_DONE;
                end
                // ---- smoothing: streamed reads, in-place writes one bin behind ----
                S_SM_RUN: begin
                    if (issue) begin
                        rd_cnt_reg    <= rd_cnt_reg + 1'b1;
                        arr_valid_reg <= 1'b1;
                        arr_idx_reg   <= rd_cnt_reg;
                    end
                    if (arr_valid_reg) begin
                        prev1_reg <= rd_val;
                        prev2_reg <= prev1_reg;
                        if (arr_idx_reg == n_last) begin
                            state_reg <= S_SM_TAIL;
                        end
                    end
                end
                S_SM_TAIL: begin
                    if (passes_reg == PASS_W'(1)) begin
                        state_reg <= S_DONE;
                    end else begin
                        passes_reg <= passes_reg - 1'b1;
                        rd_cnt_reg <= '0;
                        state_reg  <= S_SM_RUN;
                    end
                end
                // ---- normalize: sum sweep, then divide each bin ----
                S_SUM_RUN: begin
                    if (issue) begin
                        rd_cnt_reg    <= rd_cnt_reg + 1'b1;
                        arr_valid_reg <= 1'b1;
                        arr_idx_reg   <= rd_cnt_reg;
                    end
                    if (arr_valid_reg) begin
                        total_reg <= total_reg + signed'({{AW{rd_val[VAL_W-1]}}, rd_val});
                        if (arr_idx_reg == n_last) begin
                            state_reg <= S_SUM_END;
                        end
                    end
                end
                S_SUM_END: begin
                    rd_cnt_reg <= '0;
                    if (total_reg == '0) begin
                        res_status_reg <= ST_ZERO;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_N_RD;
                    end
                end
                S_N_RD: state_reg <= S_N_DAT;
                S_N_DAT: begin
                    neg_reg   <= rd_val[VAL_W-1] ^ total_reg[TW-1];
                    state_reg <= S_N_DIV;
                end
                S_N_DIV: begin
                    if (div_done) begin
                        if (rd_cnt_reg == n_last) begin
                            res_status_reg <= (sat_reg || norm_res[VAL_W]) ? ST_SAT : ST_OK;
                            state_reg      <= S_DONE;
                        end else begin
                            sat_reg    <= sat_reg || norm_res[VAL_W];
                            rd_cnt_reg <= rd_cnt_reg + 1'b1;
                            state_reg  <= S_N_RD;
                        end
                    end
                end
                // ---- weighting: per bin, exponent multiply steps ----
                S_W_RD: state_reg <= S_W_DAT;
                S_W_DAT: begin
                    val_reg   <= rd_val;
                    step_reg  <= expo_reg;
                    state_reg <= S_W_GO;
                end
                S_W_GO: state_reg <= S_W_MUL;
                S_W_MUL: begin
                    if (mul_done) begin
                        val_reg <= w_res[VAL_W-1:0];
                        if (step_reg != EXP_W'(1)) begin
                            sat_reg   <= sat_reg || w_res[VAL_W];
                            step_reg  <= step_reg - 1'b1;
                            state_reg <= S_W_GO;
                        end else if (rd_cnt_reg == n_last) begin
                            res_status_reg <= (sat_reg || w_res[VAL_W]) ? ST_SAT : ST_OK;
                            state_reg      <= S_DONE;
                        end else begin
                            sat_reg    <= sat_reg || w_res[VAL_W];
                            rd_cnt_reg <= rd_cnt_reg + 1'b1;
                            state_reg  <= S_W_RD;
                        end
                    end
                end
                // ---- read one bin ----
                S_RD_ISS: begin
                    if (idx_bad) begin
                        res_status_reg <= ST_BAD;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_RD_DAT;
                    end
                end
                S_RD_DAT: begin
                    res_value_reg <= ram_rdata;
                    res_edge_reg  <= edge_reg;
                    state_reg     <= S_DONE;
                end
                // ---- hand the result to the output register ----
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_value_reg  <= res_value_reg;
                        m_edge_reg   <= res_edge_reg;
                        m_miss_reg   <= miss_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_miss_reg, m_edge_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

    // ---------------- assertions ----------------
    // One command at a time: an accepted transaction closes the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // Miss counter only falls when a clear command is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=> (miss_reg >= $past(miss_reg)))
        else $error("miss counter decreased outside clear");

    // Outside clearing, writes stay inside the bins in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != S_INIT && state_reg != S_CLR)
            |-> (CW'(ram_waddr) < n_bins))
        else $error("bin write beyond bins in use");

    // Serial units report completion only where the sequencer waits for them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done || mul_done) |-> (state_reg == S_N_DIV || state_reg == S_W_MUL))
        else $error("arithmetic unit finished while not awaited");

endmodule
